[hdl/lidar_polar_to_pixel_plotter_top_assert.svh]
// Assertion macros used by the checker file of the plotter.
`ifndef LIDAR_POLAR_TO_PIXEL_PLOTTER_TOP_ASSERT_SVH
`define LIDAR_POLAR_TO_PIXEL_PLOTTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define LPP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lpp_pkg.sv]
package lpp_pkg;

    localparam int RING_DEPTH  = 8192;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int MAP_SIDE    = 320;
    localparam int SCREEN_LONG = 480;

    localparam int MAP_LO      = (SCREEN_LONG - MAP_SIDE) / 2;
    localparam int MAP_HI      = MAP_LO + MAP_SIDE;
    localparam int X_CENTER    = SCREEN_LONG / 2;
    localparam int Y_CENTER    = MAP_SIDE / 2;
    localparam int HALF_SIDE   = MAP_SIDE / 2;

    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 15;
    localparam int QUAL_W  = 6;
    localparam int TIME_W  = 32;
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 9;
    localparam int COLOR_W = 16;
    localparam int MS_W    = 16;

    localparam int ANGLE_FULL    = 23040;
    localparam int ANGLE_QUARTER = 5760;
    localparam int REM_W         = 13;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_X0    = 19899;
    localparam int XY_W         = 18;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;
    localparam int Q15_MAX      = 32767;
    localparam int CLAMP_W      = 15;
    localparam int SC_W         = 17;
    localparam int FRAC_BITS    = 15;

    localparam int PROD_W   = 34;
    localparam int SCALED_W = 44;
    localparam int NUM_W    = 25;
    localparam int MAG_W    = NUM_W - 1;
    localparam int QUO_W    = NUM_W;
    localparam int POS_W    = QUO_W + 1;

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int RANGE_INIT = 4000;
    localparam int QMIN_INIT  = 18;
    localparam int ONESHOT_INIT = 2000;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW  = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_QUALITY_MIN  = 2'd0,
        REG_SCALE_MODE   = 2'd1,
        REG_PERSIST_MODE = 2'd2,
        REG_ONESHOT_MS   = 2'd3
    } t_reg_idx;

    localparam logic [2:0] SCALE_AUTO = 3'd0;
    localparam logic [2:0] SCALE_1M   = 3'd1;
    localparam logic [2:0] SCALE_2M5  = 3'd2;
    localparam logic [2:0] SCALE_5M   = 3'd3;
    localparam logic [2:0] SCALE_10M  = 3'd4;

    localparam logic [1:0] PERSIST_ERASE   = 2'd0;
    localparam logic [1:0] PERSIST_ACCUM   = 2'd1;
    localparam logic [1:0] PERSIST_ONESHOT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DIV_GO,
        ST_DIV,
        ST_READ,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } t_ring_entry;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] addr;
        t_ring_entry       wdata;
    } t_ring_req;

    // atan(2^-i) in degrees scaled by 65536.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            4'd0:    v = 22'd2949120;
            4'd1:    v = 22'd1740967;
            4'd2:    v = 22'd919879;
            4'd3:    v = 22'd466945;
            4'd4:    v = 22'd234379;
            4'd5:    v = 22'd117304;
            4'd6:    v = 22'd58666;
            4'd7:    v = 22'd29335;
            4'd8:    v = 22'd14668;
            4'd9:    v = 22'd7334;
            4'd10:   v = 22'd3667;
            4'd11:   v = 22'd1833;
            4'd12:   v = 22'd917;
            4'd13:   v = 22'd458;
            4'd14:   v = 22'd229;
            default: v = 22'd115;
        endcase
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] mode_range(input logic [2:0] m);
        logic [DIST_W-1:0] v;
        case (m)
            SCALE_2M5: v = 16'd10000;
            SCALE_5M:  v = 16'd20000;
            SCALE_10M: v = 16'd40000;
            default:   v = DIST_W'(RANGE_INIT);
        endcase
        return v;
    endfunction

    // RGB565 of red 255-4q, green 4q, blue 0.
    function automatic logic [COLOR_W-1:0] pixel_color(input logic [QUAL_W-1:0] q);
        logic [7:0] r;
        logic [7:0] g;
        g = {q, 2'b00};
        r = 8'd255 - g;
        return {r[7:3], g[7:2], 5'b00000};
    endfunction

endpackage

[hdl/lpp_in_if.sv]
interface lpp_in_if;
    import lpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance_q2;
    logic [ANGLE_W-1:0]  angle_q6;
    logic [QUAL_W-1:0]   quality;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, distance_q2, angle_q6, quality, now_ms, input ready);
    modport sink   (input valid, distance_q2, angle_q6, quality, now_ms, output ready);
endinterface

[hdl/lpp_out_if.sv]
interface lpp_out_if;
    import lpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [COLOR_W-1:0]  color;
    logic                last;

    modport source (output valid, command, pixel_x, pixel_y, color, last, input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, color, last, output ready);
endinterface

[hdl/lpp_cordic.sv]
module lpp_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [lpp_pkg::Z_W-1:0] i_z,
    output logic                           o_done,
    output logic signed [lpp_pkg::XY_W-1:0] o_x,
    output logic signed [lpp_pkg::XY_W-1:0] o_y
);
    import lpp_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic signed [Z_W-1:0]    r_z;
    logic signed [XY_W-1:0]   n_x;
    logic signed [XY_W-1:0]   n_y;
    logic signed [Z_W-1:0]    n_z;
    logic signed [XY_W-1:0]   sx;
    logic signed [XY_W-1:0]   sy;
    logic signed [Z_W-1:0]    ang;

    always_comb begin
        sx  = r_x >>> r_step;
        sy  = r_y >>> r_step;
        ang = $signed({{(Z_W-ATAN_W){1'b0}}, atan_entry(r_step)});
        if (!r_z[Z_W-1]) begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= XY_W'(CORDIC_X0);
            r_y <= '0;
            r_z <= i_z;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
endmodule

[hdl/lpp_div.sv]
module lpp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [lpp_pkg::NUM_W-1:0]  i_num,
    input  logic [lpp_pkg::DIST_W-1:0]        i_den,
    output logic                              o_done,
    output logic signed [lpp_pkg::QUO_W-1:0]  o_quo
);
    import lpp_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [MAG_W-1:0]     r_mag;
    logic [DIST_W-1:0]    r_rem;
    logic [DIST_W-1:0]    r_den;
    logic [DIST_W:0]      trial;
    logic                 fits;
    logic [NUM_W-1:0]     neg_num;
    logic signed [QUO_W-1:0] quo_pos;

    assign trial   = {r_rem, r_mag[MAG_W-1]};
    assign fits    = trial >= {1'b0, r_den};
    assign neg_num = -i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle, on the magnitude.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_mag <= i_num[NUM_W-1] ? neg_num[MAG_W-1:0] : i_num[MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_mag <= {r_mag[MAG_W-2:0], fits};
            r_rem <= fits ? DIST_W'(trial - {1'b0, r_den}) : trial[DIST_W-1:0];
        end
    end

    // Floor semantics: a negative quotient with a remainder rounds down.
    assign quo_pos = $signed({1'b0, r_mag});
    assign o_quo   = r_neg ? -(quo_pos + QUO_W'(r_rem != '0)) : quo_pos;
    assign o_done  = r_done;
endmodule

[hdl/lpp_ring.sv]
module lpp_ring (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpp_pkg::t_ring_req   i_req,
    output lpp_pkg::t_ring_entry o_rdata,
    output logic                 o_busy
);
    import lpp_pkg::*;

    t_ring_entry       mem [RING_DEPTH];
    t_ring_entry       r_rdata;
    logic              r_busy;
    logic [SLOT_W-1:0] r_clr_addr;

    // After reset every entry is swept to empty, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SLOT_W'(RING_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;
endmodule

[hdl/lidar_polar_to_pixel_plotter_top.sv]
// Channel   Direction  Handshake      Item
// i_in      sink       valid/ready    distance_q2, angle_q6, quality, now_ms
// o_out     source     valid/ready    command, pixel_x, pixel_y, color, last
// APB       slave      psel/penable   quality_min, scale_mode, persist_mode, oneshot_ms
//
// One sample is worked at a time, through the 16-step CORDIC and the
// 24-step floor dividers.
// A rejected sample goes from the check state straight back to idle, which frees the input.
// After reset the history ring is swept empty, all RING_DEPTH (8192) entries;
// no sample is accepted during the sweep, while register writes are.
// Results leave through an output register, so a stalled sink holds the last
// result while the next sample is already taken.
module lidar_polar_to_pixel_plotter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lpp_in_if.sink                       i_in,
    lpp_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lpp_pkg::PDATA_W-1:0]  pwdata,
    output logic [lpp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lpp_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [QUAL_W-1:0]  r_quality_min;
    logic [2:0]         r_scale_mode;
    logic [1:0]         r_persist_mode;
    logic [MS_W-1:0]    r_oneshot_ms;
    logic [DIST_W-1:0]  r_range;
    logic [SLOT_W-1:0]  r_ring_index;
    logic               r_started;
    logic [TIME_W-1:0]  r_start_ms;
    logic               r_on_map;
    logic               r_pend_clear;
    logic               r_pend_erase;
    logic               r_pend_draw;

    logic [DIST_W-1:0]  r_dist;
    logic [ANGLE_W-1:0] r_angle;
    logic [QUAL_W-1:0]  r_quality;
    logic [TIME_W-1:0]  r_now;
    logic [1:0]         r_quad;
    logic signed [SC_W-1:0]   r_s;
    logic signed [SC_W-1:0]   r_nc;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_py;
    logic [PIX_W-1:0]   r_erase_x;
    logic [PIX_W-1:0]   r_erase_y;

    logic               r_out_valid;
    logic [CMD_W-1:0]   r_out_command;
    logic [PIX_W-1:0]   r_out_x;
    logic [PIX_W-1:0]   r_out_y;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    logic               in_ready;
    logic               accept;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic               reject;
    logic               grow;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [XY_W-1:0] cordic_x;
    logic signed [XY_W-1:0] cordic_y;
    logic [ANGLE_W-1:0] ang_red;
    logic [1:0]         quad;
    logic [REM_W-1:0]   ang_rem;
    logic signed [Z_W-1:0] z0;
    logic [CLAMP_W-1:0] cx;
    logic [CLAMP_W-1:0] cy;
    logic signed [SC_W-1:0] pos_x;
    logic signed [SC_W-1:0] pos_y;
    logic signed [SC_W-1:0] sin_v;
    logic signed [SC_W-1:0] cos_v;
    logic signed [SC_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic               div_start;
    logic               div_done;
    logic               div_done_y;
    logic signed [QUO_W-1:0] quo_x;
    logic signed [QUO_W-1:0] quo_y;
    logic signed [POS_W-1:0] px_full;
    logic signed [POS_W-1:0] py_full;
    logic               on_map;
    t_ring_req          ring_req;
    t_ring_entry        ring_rdata;
    logic               ring_busy;
    logic [TIME_W-1:0]  start_v;
    logic [TIME_W-1:0]  elapsed;
    logic               dec_draw;
    logic               dec_erase;
    logic               dec_start_set;
    logic               out_free;
    logic               any_pend;
    logic               one_pend;
    logic               emit_load;
    logic [CMD_W-1:0]   emit_cmd;
    logic [PIX_W-1:0]   emit_x;
    logic [PIX_W-1:0]   emit_y;
    logic [COLOR_W-1:0] emit_color;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_QUALITY_MIN:  prdata = PDATA_W'(r_quality_min);
            REG_SCALE_MODE:   prdata = PDATA_W'(r_scale_mode);
            REG_PERSIST_MODE: prdata = PDATA_W'(r_persist_mode);
            REG_ONESHOT_MS:   prdata = PDATA_W'(r_oneshot_ms);
            default:          prdata = '0;
        endcase
    end

    assign in_ready   = (r_state == ST_IDLE) && !ring_busy;
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    assign reject = (r_dist == '0) || (r_quality < r_quality_min);
    assign grow   = ((r_scale_mode == SCALE_AUTO) || (r_scale_mode > SCALE_10M))
                    && (r_dist > r_range);

    // Angle reduction into a quadrant and an offset within it.
    always_comb begin
        ang_red = (r_angle >= ANGLE_W'(ANGLE_FULL)) ? ANGLE_W'(r_angle - ANGLE_W'(ANGLE_FULL))
                                                   : r_angle;
        if (ang_red >= ANGLE_W'(3 * ANGLE_QUARTER)) begin
            quad    = 2'd3;
            ang_rem = REM_W'(ang_red - ANGLE_W'(3 * ANGLE_QUARTER));
        end else if (ang_red >= ANGLE_W'(2 * ANGLE_QUARTER)) begin
            quad    = 2'd2;
            ang_rem = REM_W'(ang_red - ANGLE_W'(2 * ANGLE_QUARTER));
        end else if (ang_red >= ANGLE_W'(ANGLE_QUARTER)) begin
            quad    = 2'd1;
            ang_rem = REM_W'(ang_red - ANGLE_W'(ANGLE_QUARTER));
        end else begin
            quad    = 2'd0;
            ang_rem = REM_W'(ang_red);
        end
        z0 = $signed(Z_W'({ang_rem, 10'b0}));
    end

    // Clamp the CORDIC result to Q1.15 and unfold the quadrant.
    always_comb begin
        if (cordic_x < 0) begin
            cx = '0;
        end else if (cordic_x > XY_W'(Q15_MAX)) begin
            cx = CLAMP_W'(Q15_MAX);
        end else begin
            cx = cordic_x[CLAMP_W-1:0];
        end
        if (cordic_y < 0) begin
            cy = '0;
        end else if (cordic_y > XY_W'(Q15_MAX)) begin
            cy = CLAMP_W'(Q15_MAX);
        end else begin
            cy = cordic_y[CLAMP_W-1:0];
        end
        pos_x = $signed({2'b00, cx});
        pos_y = $signed({2'b00, cy});
        case (r_quad)
            2'd0:    begin sin_v = pos_y;  cos_v = pos_x;  end
            2'd1:    begin sin_v = pos_x;  cos_v = -pos_y; end
            2'd2:    begin sin_v = -pos_y; cos_v = -pos_x; end
            default: begin sin_v = -pos_x; cos_v = pos_y;  end
        endcase
    end

    // One multiplier, used for x and then for y.
    assign mul_b = (r_state == ST_MUL_X) ? r_s : r_nc;
    assign mul_p = PROD_W'($signed({1'b0, r_dist}) * mul_b);

    assign scaled_x = SCALED_W'(r_prod_x) * SCALED_W'(HALF_SIDE);
    assign scaled_y = SCALED_W'(r_prod_y) * SCALED_W'(HALF_SIDE);
    assign num_x    = NUM_W'(scaled_x >>> FRAC_BITS);
    assign num_y    = NUM_W'(scaled_y >>> FRAC_BITS);

    always_comb begin
        px_full = $signed(POS_W'(X_CENTER)) + POS_W'(quo_x);
        py_full = $signed(POS_W'(Y_CENTER)) + POS_W'(quo_y);
        on_map  = (px_full >= $signed(POS_W'(MAP_LO))) && (px_full <= $signed(POS_W'(MAP_HI)))
                  && (py_full >= 0) && (py_full <= $signed(POS_W'(MAP_SIDE)));
    end

    // Persistence decision on the old ring entry.
    always_comb begin
        start_v       = r_started ? r_start_ms : r_now;
        elapsed       = r_now - start_v;
        dec_draw      = 1'b1;
        dec_erase     = 1'b0;
        dec_start_set = 1'b0;
        if (ring_rdata.valid) begin
            if (r_persist_mode == PERSIST_ONESHOT) begin
                dec_start_set = 1'b1;
                if (elapsed > TIME_W'(r_oneshot_ms)) begin
                    dec_draw = 1'b0;
                end
            end else if (r_persist_mode != PERSIST_ACCUM) begin
                dec_erase = 1'b1;
            end
        end
    end

    // Result selection: clear, then erase, then draw.
    assign out_free = !r_out_valid || o_out.ready;
    assign any_pend = r_pend_clear || r_pend_erase || r_pend_draw;
    assign one_pend = (2'(r_pend_clear) + 2'(r_pend_erase) + 2'(r_pend_draw)) == 2'd1;

    always_comb begin
        if (r_pend_clear) begin
            emit_cmd   = CMD_CLEAR;
            emit_x     = '0;
            emit_y     = '0;
            emit_color = '0;
        end else if (r_pend_erase) begin
            emit_cmd   = CMD_ERASE;
            emit_x     = r_erase_x;
            emit_y     = r_erase_y;
            emit_color = '0;
        end else begin
            emit_cmd   = CMD_DRAW;
            emit_x     = r_px;
            emit_y     = r_py;
            emit_color = pixel_color(r_quality);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_CHECK;
            ST_CHECK:  n_state = reject ? ST_IDLE : ST_CORDIC;
            ST_CORDIC: if (cordic_done) n_state = ST_MUL_X;
            ST_MUL_X:  n_state = ST_MUL_Y;
            ST_MUL_Y:  n_state = ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV;
            ST_DIV:    if (div_done && div_done_y) n_state = ST_READ;
            ST_READ:   n_state = r_on_map ? ST_DECIDE : ST_EMIT;
            ST_DECIDE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!any_pend || (out_free && one_pend)) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cordic_start      = (r_state == ST_CHECK) && !reject;
        div_start         = (r_state == ST_DIV_GO);
        emit_load         = (r_state == ST_EMIT) && out_free && any_pend;
        ring_req.rd_en    = (r_state == ST_READ) && r_on_map;
        ring_req.wr_en    = (r_state == ST_DECIDE) && dec_draw;
        ring_req.addr     = r_ring_index;
        ring_req.wdata    = '{valid: 1'b1, y: r_py, x: r_px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_quality_min  <= QUAL_W'(QMIN_INIT);
            r_scale_mode   <= SCALE_AUTO;
            r_persist_mode <= PERSIST_ERASE;
            r_oneshot_ms   <= MS_W'(ONESHOT_INIT);
            r_range        <= DIST_W'(RANGE_INIT);
            r_ring_index   <= '0;
            r_started      <= 1'b0;
            r_start_ms     <= '0;
            r_on_map       <= 1'b0;
            r_pend_clear   <= 1'b0;
            r_pend_erase   <= 1'b0;
            r_pend_draw    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cordic_start && grow) begin
                r_range      <= r_dist;
                r_started    <= 1'b0;
                r_pend_clear <= 1'b1;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_QUALITY_MIN:  r_quality_min <= pwdata[QUAL_W-1:0];
                    REG_SCALE_MODE: begin
                        r_scale_mode <= pwdata[2:0];
                        r_range      <= mode_range(pwdata[2:0]);
                    end
                    REG_PERSIST_MODE: r_persist_mode <= pwdata[1:0];
                    REG_ONESHOT_MS:   r_oneshot_ms   <= pwdata[MS_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == ST_DIV) && div_done && div_done_y) begin
                r_on_map <= on_map;
            end
            if (r_state == ST_DECIDE) begin
                r_pend_erase <= dec_erase;
                r_pend_draw  <= dec_draw;
                if (dec_start_set) begin
                    r_started  <= 1'b1;
                    r_start_ms <= start_v;
                end
                r_ring_index <= (r_ring_index == SLOT_W'(RING_DEPTH - 1)) ? '0
                                : r_ring_index + 1'b1;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
                if (r_pend_clear) begin
                    r_pend_clear <= 1'b0;
                end else if (r_pend_erase) begin
                    r_pend_erase <= 1'b0;
                end else begin
                    r_pend_draw <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dist    <= i_in.distance_q2;
            r_angle   <= i_in.angle_q6;
            r_quality <= i_in.quality;
            r_now     <= i_in.now_ms;
        end
        if (cordic_start) begin
            r_quad <= quad;
        end
        if ((r_state == ST_CORDIC) && cordic_done) begin
            r_s  <= sin_v;
            r_nc <= -cos_v;
        end
        if (r_state == ST_MUL_X) begin
            r_prod_x <= mul_p;
        end
        if (r_state == ST_MUL_Y) begin
            r_prod_y <= mul_p;
        end
        if ((r_state == ST_DIV) && div_done && div_done_y) begin
            r_px <= px_full[PIX_W-1:0];
            r_py <= py_full[PIX_W-1:0];
        end
        if (r_state == ST_DECIDE) begin
            r_erase_x <= ring_rdata.x;
            r_erase_y <= ring_rdata.y;
        end
        if (emit_load) begin
            r_out_command <= emit_cmd;
            r_out_x       <= emit_x;
            r_out_y       <= emit_y;
            r_out_color   <= emit_color;
            r_out_last    <= one_pend;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.command = r_out_command;
    assign o_out.pixel_x = r_out_x;
    assign o_out.pixel_y = r_out_y;
    assign o_out.color   = r_out_color;
    assign o_out.last    = r_out_last;

    lpp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_z     (z0),
        .o_done  (cordic_done),
        .o_x     (cordic_x),
        .o_y     (cordic_y)
    );

    lpp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x),
        .i_den   (r_range),
        .o_done  (div_done),
        .o_quo   (quo_x)
    );

    // Started together with the x divider; both must be done to go on.
    lpp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_y),
        .i_den   (r_range),
        .o_done  (div_done_y),
        .o_quo   (quo_y)
    );

    lpp_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rdata (ring_rdata),
        .o_busy  (ring_busy)
    );
endmodule

[hdl/lpp_checker.sv]
`include "lidar_polar_to_pixel_plotter_top_assert.svh"

module lpp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lpp_pkg::CMD_W-1:0]    i_out_command,
    input logic [lpp_pkg::PIX_W-1:0]    i_out_pixel_x,
    input logic [lpp_pkg::PIX_W-1:0]    i_out_pixel_y,
    input logic [lpp_pkg::COLOR_W-1:0]  i_out_color,
    input logic                         i_out_last
);
    import lpp_pkg::*;

    // A stalled result keeps its payload.
    `LPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_command, i_out_pixel_x, i_out_pixel_y, i_out_color, i_out_last}), "stalled result changed")

    // Erase and clear carry black; no unknown command leaves.
    `LPP_ASSERT_NOW(a_cmd_color, i_clk, i_rst_n, i_out_valid && (i_out_command != CMD_DRAW), (i_out_color == '0) && ((i_out_command == CMD_ERASE) || (i_out_command == CMD_CLEAR)), "bad command or color")

    // One sample at a time: no item is taken right after another.
    `LPP_ASSERT_NEXT(a_in_gap, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "back to back input item")

    // Reset empties the output and blocks input for the ring sweep.
    `LPP_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid && !i_in_ready, "activity after reset")
endmodule

bind lidar_polar_to_pixel_plotter_top lpp_checker u_lpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_command (o_out.command),
    .i_out_pixel_x (o_out.pixel_x),
    .i_out_pixel_y (o_out.pixel_y),
    .i_out_color   (o_out.color),
    .i_out_last    (o_out.last)
);
